@@ rtl/core/obt_pkg.sv @@
// Shared types and constants of the owned block table.
package obt_pkg;

   localparam int TABLE_DEPTH_DEF = 32;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_CHECK   = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NOT_FOUND = 3'd1,
      STATUS_TOO_SMALL = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] offset;
      logic [63:0] size;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] offset;
      logic        last;
   } rsp_type;

endpackage

@@ rtl/core/obt_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module obt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/obt_front.sv @@
// Front end: decodes request items and holds them in a two-entry command queue.
module obt_front import obt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  mode,
   input  logic [63:0] block_offset,
   input  logic [63:0] block_size,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output cmd_type     cmd
);

   cmd_type    slot0_ff, slot0_in;
   cmd_type    slot1_ff, slot1_in;
   logic [1:0] level_ff, level_in;
   cmd_type    decoded;
   logic       do_push;
   logic       do_pop;

   assign decoded.op     = op_type'(mode);
   assign decoded.offset = block_offset;
   assign decoded.size   = block_size;

   assign full      = (level_ff == 2'd2);
   assign cmd_valid = (level_ff != 2'd0);
   assign cmd       = slot0_ff;
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      level_in = level_ff;
      if (do_pop) begin
         slot0_in = slot1_ff;
         level_in = level_in - 2'd1;
      end
      if (do_push) begin
         if (level_in == 2'd0) begin
            slot0_in = decoded;
         end else begin
            slot1_in = decoded;
         end
         level_in = level_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

@@ rtl/core/obt_rsp_queue.sv @@
// Two-entry result queue that decouples the back end from the result receiver.
module obt_rsp_queue import obt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    empty,
   input  logic    pop,
   output rsp_type head
);

   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] level_ff, level_in;
   logic       do_push;
   logic       do_pop;

   assign space   = (level_ff != 2'd2);
   assign empty   = (level_ff == 2'd0);
   assign head    = slot0_ff;
   assign do_push = push && space;
   assign do_pop  = pop && !empty;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      level_in = level_ff;
      if (do_pop) begin
         slot0_in = slot1_ff;
         level_in = level_in - 2'd1;
      end
      if (do_push) begin
         if (level_in == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         level_in = level_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

@@ rtl/core/obt_back.sv @@
// Back end: executes commands against the entry memories with a pipelined walk.
module obt_back import obt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  cmd_type cmd,
   output logic    res_push,
   output rsp_type res_data,
   input  logic    res_space
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   op_type      op_ff, op_in;
   logic [63:0] key_ff, key_in;
   logic [63:0] size_ff, size_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic        cmp_valid_ff, cmp_valid_in;
   logic [CW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0] hole_ff, hole_in;
   status_type  status_ff, status_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [63:0]   wr_off;
   logic [63:0]   wr_size;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [63:0]   rd_off;
   logic [63:0]   rd_size;
   logic [CW-1:0] count_m1;
   logic          last_idx;
   logic          hit;
   logic          advance;
   logic          issue_lt;

   obt_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH), .AW(IW)) u_offsets (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_off),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_off)
   );

   obt_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH), .AW(IW)) u_sizes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_size),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_size)
   );

   assign count_m1 = count_ff - CW'(1);
   assign last_idx = (cmp_idx_ff == count_m1);
   assign hit      = cmp_valid_ff && (rd_off == key_ff);
   assign issue_lt = (issue_ff < count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      size_in      = size_ff;
      issue_in     = issue_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      hole_in      = hole_ff;
      status_in    = status_ff;
      cmd_take     = 1'b0;
      res_push     = 1'b0;
      res_data     = '{status: STATUS_OK, offset: 64'd0, last: 1'b1};
      wr_en        = 1'b0;
      wr_addr      = count_ff[IW-1:0];
      wr_off       = cmd.offset;
      wr_size      = cmd.size;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[IW-1:0];
      advance      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take     = 1'b1;
               op_in        = cmd.op;
               key_in       = cmd.offset;
               size_in      = cmd.size;
               issue_in     = '0;
               cmp_valid_in = 1'b0;
               state_in     = ST_EMIT;
               unique case (cmd.op)
                  OP_INSERT: begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        count_in  = count_ff + CW'(1);
                        status_in = STATUS_OK;
                     end
                  end
                  OP_REMOVE, OP_CHECK: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_RELEASE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     status_in = STATUS_NOT_FOUND;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_RELEASE) begin
               if (cmp_valid_ff) begin
                  if (res_space) begin
                     res_push = 1'b1;
                     res_data = '{status: STATUS_OK, offset: rd_off, last: last_idx};
                     if (last_idx) begin
                        count_in = '0;
                        state_in = ST_IDLE;
                     end else begin
                        advance = 1'b1;
                     end
                  end
               end else begin
                  advance = 1'b1;
               end
            end else if (hit) begin
               if (op_ff == OP_CHECK) begin
                  status_in = (rd_size >= size_ff) ? STATUS_OK : STATUS_TOO_SMALL;
                  state_in  = ST_EMIT;
               end else begin
                  hole_in = cmp_idx_ff;
                  if (last_idx) begin
                     count_in  = count_m1;
                     status_in = STATUS_OK;
                     state_in  = ST_EMIT;
                  end else begin
                     state_in = ST_MOVE_RD;
                  end
               end
            end else if (cmp_valid_ff && last_idx) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_EMIT;
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               rd_en        = issue_lt;
               cmp_valid_in = issue_lt;
               cmp_idx_in   = issue_ff;
               if (issue_lt) begin
                  issue_in = issue_ff + CW'(1);
               end
            end
         end
         ST_MOVE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = count_m1[IW-1:0];
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            wr_en     = 1'b1;
            wr_addr   = hole_ff[IW-1:0];
            wr_off    = rd_off;
            wr_size   = rd_size;
            count_in  = count_m1;
            status_in = STATUS_OK;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (res_space) begin
               res_push = 1'b1;
               res_data = '{status: status_ff, offset: 64'd0, last: 1'b1};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      size_ff    <= size_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      hole_ff    <= hole_in;
      status_ff  <= status_in;
   end

endmodule

@@ rtl/core/owned_block_table_top.sv @@
// Top level of the owned block table: front end, back end and result queue.
//
// Request items are pushed with req_push while req_full is low; each carries
// req_mode (insert, remove, check, release), req_block_offset and
// req_block_size. A two-entry command queue holds them for the back end.
// Results come out of a two-entry queue: while rsp_empty is low the oldest
// result item is on rsp_status, rsp_released_offset and rsp_last, and it is
// taken with rsp_pop. Insert, remove and check give one item; release gives
// one item per stored entry, with rsp_last on the final one, or a single
// STATUS_EMPTY item when the table is empty. Offsets and sizes live in two
// RAMs with a registered read; the walk over entries reads one entry per
// cycle through that single read port, except while a release walk waits
// for result queue space. Insert writes the new entry behind the last one;
// check and remove walk until the offset matches, and remove then moves the
// last entry into the freed slot. Release walks every entry and empties it.
// Reset empties the table and both queues; entry memories are not cleared.
// When the receiver stalls the result queue fills, the back end holds its
// result or walk in place, and the command queue then raises req_full.
module owned_block_table_top import obt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_block_offset,
   input  logic [63:0] req_block_size,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_released_offset,
   output logic        rsp_last
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;
   logic    res_push;
   rsp_type res_data;
   logic    res_space;
   rsp_type head;

   obt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .mode         (req_mode),
      .block_offset (req_block_offset),
      .block_size   (req_block_size),
      .cmd_valid    (cmd_valid),
      .cmd_take     (cmd_take),
      .cmd          (cmd)
   );

   obt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .res_push  (res_push),
      .res_data  (res_data),
      .res_space (res_space)
   );

   obt_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .space     (res_space),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (head)
   );

   assign rsp_status          = head.status;
   assign rsp_released_offset = head.offset;
   assign rsp_last            = head.last;

endmodule
